/* rtl/assert_macros.svh */
// Assertion macros used by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed: implication does not hold");
// Invariant checked at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
	label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("assertion failed: invariant does not hold");
`else
`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_ALWAYS(label, clk, rstn, expr)
`endif

`endif

/* rtl/dtjd_pkg.sv */
// Types, constants and the delta-T table for the delta-T pipeline.
`default_nettype none

package dtjd_pkg;

	// Payload types
	typedef logic [26:0]        jd_t;
	typedef logic signed [30:0] dt_ms_t;
	typedef logic signed [15:0] rom_word_t;

	// Which formula a date falls under
	typedef enum logic [1:0] {
		SEG_EARLY,
		SEG_MID,
		SEG_TABLE
	} seg_t;

	// JD 2451545.0 in 1/16 day
	localparam logic [27:0] JD2000_Q4 = 28'd39224720;
	// 2^48 / (16 * 365.25), rounded; applied as two 18-bit halves
	localparam logic [35:0] YEAR_RECIP = 36'd48164780409;
	// floor(x / 100) = (x * DIV100_MAGIC) >> 37 for x below 2^32
	localparam logic [30:0] DIV100_MAGIC = 31'd1374389535;

	// Segment bounds in Q.16 years from 2000
	localparam logic signed [30:0] YEAR_EARLY = -31'sd68943872; // year 948
	localparam logic signed [30:0] YEAR_MID   = -31'sd24903680; // year 1620
	localparam logic signed [31:0] TABLE_OFS  = 32'sd24903680;

	// Quadratic coefficients in ms: c0 + c1*t + c2*t^2, t in centuries
	localparam logic [21:0] EARLY_C0 = 22'd2715600;
	localparam logic [19:0] EARLY_C1 = 20'd573360;
	localparam logic [15:0] EARLY_C2 = 16'd46500;
	localparam logic [21:0] MID_C0   = 22'd50600;
	localparam logic [19:0] MID_C1   = 20'd67500;
	localparam logic [15:0] MID_C2   = 16'd22500;

	localparam logic [31:0] MS_LIMIT = 32'd1000000000;

	// Delta-T at two-year steps from 1620, in units of 10 ms
	localparam int ROM_SIZE = 205;
	localparam int ROM_AW   = 8;
	localparam rom_word_t DT_ROM [ROM_SIZE] = '{
		16'sd12400, 16'sd11500, 16'sd10600, 16'sd9800, 16'sd9100, 16'sd8500, 16'sd7900,
		16'sd7400, 16'sd7000, 16'sd6500, 16'sd6200, 16'sd5800, 16'sd5500, 16'sd5300,
		16'sd5000, 16'sd4800, 16'sd4600, 16'sd4400, 16'sd4200, 16'sd4000, 16'sd3700,
		16'sd3500, 16'sd3300, 16'sd3100, 16'sd2800, 16'sd2600, 16'sd2400, 16'sd2200,
		16'sd2000, 16'sd1800, 16'sd1600, 16'sd1400, 16'sd1300, 16'sd1200, 16'sd1100,
		16'sd1000, 16'sd900, 16'sd900, 16'sd900, 16'sd900, 16'sd900, 16'sd900,
		16'sd900, 16'sd900, 16'sd1000, 16'sd1000, 16'sd1000, 16'sd1000, 16'sd1000,
		16'sd1100, 16'sd1100, 16'sd1100, 16'sd1100, 16'sd1100, 16'sd1100, 16'sd1100,
		16'sd1100, 16'sd1200, 16'sd1200, 16'sd1200, 16'sd1200, 16'sd1200, 16'sd1300,
		16'sd1300, 16'sd1300, 16'sd1300, 16'sd1400, 16'sd1400, 16'sd1400, 16'sd1500,
		16'sd1500, 16'sd1500, 16'sd1500, 16'sd1600, 16'sd1600, 16'sd1600, 16'sd1600,
		16'sd1600, 16'sd1700, 16'sd1700, 16'sd1700, 16'sd1700, 16'sd1700, 16'sd1700,
		16'sd1700, 16'sd1700, 16'sd1600, 16'sd1600, 16'sd1500, 16'sd1400, 16'sd1370,
		16'sd1310, 16'sd1270, 16'sd1250, 16'sd1250, 16'sd1250, 16'sd1250, 16'sd1250,
		16'sd1250, 16'sd1230, 16'sd1200, 16'sd1140, 16'sd1060, 16'sd960, 16'sd860,
		16'sd750, 16'sd660, 16'sd600, 16'sd570, 16'sd560, 16'sd570, 16'sd590,
		16'sd620, 16'sd650, 16'sd680, 16'sd710, 16'sd730, 16'sd750, 16'sd770,
		16'sd780, 16'sd790, 16'sd750, 16'sd640, 16'sd540, 16'sd290, 16'sd160,
		-16'sd100, -16'sd270, -16'sd360, -16'sd470, -16'sd540, -16'sd520, -16'sd550,
		-16'sd560, -16'sd580, -16'sd590, -16'sd620, -16'sd640, -16'sd610, -16'sd470,
		-16'sd270, 16'sd0, 16'sd260, 16'sd540, 16'sd770, 16'sd1050, 16'sd1340,
		16'sd1600, 16'sd1820, 16'sd2020, 16'sd2120, 16'sd2240, 16'sd2350, 16'sd2390,
		16'sd2430, 16'sd2400, 16'sd2390, 16'sd2390, 16'sd2370, 16'sd2400, 16'sd2430,
		16'sd2530, 16'sd2620, 16'sd2730, 16'sd2820, 16'sd2910, 16'sd3000, 16'sd3070,
		16'sd3140, 16'sd3220, 16'sd3310, 16'sd3400, 16'sd3500, 16'sd3650, 16'sd3830,
		16'sd4020, 16'sd4220, 16'sd4450, 16'sd4650, 16'sd4850, 16'sd5050, 16'sd5220,
		16'sd5380, 16'sd5490, 16'sd5580,
		16'sd5686, 16'sd5831, 16'sd5998, 16'sd6163, 16'sd6297, 16'sd6383, 16'sd6430,
		16'sd6457, 16'sd6485, 16'sd6546,
		16'sd6570, 16'sd6650, 16'sd6710, 16'sd6800, 16'sd6800, 16'sd6900, 16'sd6900,
		16'sd7000, 16'sd7000,
		// last slot is unpopulated and reads as zero
		16'sd0
	};

endpackage

`default_nettype wire

/* rtl/delta_t_from_julian_date.sv */
// Top level: ten-stage pipeline from Julian date to delta-T in milliseconds.
//
// Takes one Julian date (1/16 day units) per request and returns delta-T (TD - UT) in
// signed milliseconds, saturated to +-1e9. Throughput is one date per clock unless
// dt_ready is held low. The accept edge loads the first stage, and the result moves
// through stages S2 to S10 into the output register, from which it leaves on dt_ready.
// The depth is set by the multiplier chain: the 27x36 year reciprocal is split into
// two 18-bit partial products, the divide by 100 is a reciprocal multiply, and the
// quadratic / table interpolation and their 64-bit combine each take their own
// registered multiply stage. Every stage holds its own valid bit and the pipeline
// only stops moving where a valid item meets a stalled successor, so bubbles are
// squeezed out and a stalled output costs nothing upstream until the pipe fills.
// TABLE_ENTRIES limits how much of the built-in table is interpolated; past its
// end the last segment is extended and a quadratic correction is added.
`default_nettype none
`include "assert_macros.svh"

module delta_t_from_julian_date #(
	parameter int TABLE_ENTRIES = 205
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             jd_valid,
	output logic             jd_ready,
	input  dtjd_pkg::jd_t    julian_date_q4,
	output logic             dt_valid,
	input  logic             dt_ready,
	output dtjd_pkg::dt_ms_t delta_t_ms
);
	import dtjd_pkg::*;

	localparam int STAGES    = 10;
	localparam int LIMIT_RAW = (TABLE_ENTRIES < ROM_SIZE) ? TABLE_ENTRIES : ROM_SIZE;
	localparam int LIMIT     = (LIMIT_RAW < 2) ? 2 : LIMIT_RAW;
	localparam int IDX_MAX   = LIMIT - 2;
	localparam int IDX_W     = $clog2(LIMIT);
	localparam dt_ms_t DT_MS_MAX = 31'sd1000000000;

	// Handshake: per-stage valid and load enable
	logic [STAGES:1] vld_q;
	logic [STAGES:1] stage_en;

	always_comb begin
		stage_en[STAGES] = !vld_q[STAGES] || dt_ready;
		for (int k = STAGES - 1; k >= 1; k--) begin
			stage_en[k] = !vld_q[k] || stage_en[k + 1];
		end
	end

	assign jd_ready = stage_en[1];
	assign dt_valid = vld_q[STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stage_en[1]) begin
				vld_q[1] <= jd_valid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (stage_en[k]) begin
					vld_q[k] <= vld_q[k - 1];
				end
			end
		end
	end

	// S1: day offset from J2000 as sign and magnitude
	logic signed [27:0] day_ofs;
	logic [26:0]        mag_s1;
	logic               neg_s1;

	assign day_ofs = $signed({1'b0, julian_date_q4}) - $signed(JD2000_Q4);

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			neg_s1 <= day_ofs[27];
			mag_s1 <= day_ofs[27] ? 27'(-day_ofs) : 27'(day_ofs);
		end
	end

	// S2: partial products of magnitude times year reciprocal
	logic [44:0] pl_s2;
	logic [44:0] ph_s2;
	logic        neg_s2;

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			neg_s2 <= neg_s1;
			pl_s2  <= 45'(mag_s1) * 45'(YEAR_RECIP[17:0]);
			ph_s2  <= 45'(mag_s1) * 45'(YEAR_RECIP[35:18]);
		end
	end

	// S3: combine, round to nearest, apply sign -> Q.16 years
	logic [62:0]        yr_sum;
	logic [29:0]        yr_mag;
	logic signed [30:0] years_s3;

	assign yr_sum = {ph_s2, 18'd0} + 63'(pl_s2) + 63'h8000_0000;
	assign yr_mag = yr_sum[61:32];

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			years_s3 <= neg_s2 ? -$signed({1'b0, yr_mag}) : $signed({1'b0, yr_mag});
		end
	end

	// S4: segment select; centuries divide; table index and fraction
	seg_t               seg_w;
	logic [29:0]        neg_years;
	logic [29:0]        cent_num;
	logic signed [31:0] tab_u;
	logic [29:0]        tab_step;
	logic [13:0]        idx_raw;
	logic [IDX_W-1:0]   idx_w;
	logic [29:0]        frac_w;
	seg_t               seg_s4;
	logic [60:0]        q100_s4;
	logic [IDX_W-1:0]   idx_s4;
	logic [29:0]        frac_s4;

	always_comb begin
		priority if (years_s3 < YEAR_EARLY) begin
			seg_w = SEG_EARLY;
		end else if (years_s3 < YEAR_MID) begin
			seg_w = SEG_MID;
		end else begin
			seg_w = SEG_TABLE;
		end
	end

	// years are negative in both quadratic segments
	assign neg_years = 30'(-years_s3);
	assign cent_num  = neg_years + 30'd50;

	assign tab_u    = 32'(years_s3) + TABLE_OFS;
	assign tab_step = tab_u[30:1];
	assign idx_raw  = tab_step[29:16];

	// clamp at the last segment; fraction then runs past one step
	always_comb begin
		if (idx_raw > 14'(IDX_MAX)) begin
			idx_w = IDX_W'(IDX_MAX);
		end else begin
			idx_w = IDX_W'(idx_raw);
		end
		frac_w = tab_step - (30'(idx_w) << 16);
	end

	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			seg_s4  <= seg_w;
			q100_s4 <= 61'(cent_num) * 61'(DIV100_MAGIC);
			idx_s4  <= idx_w;
			frac_s4 <= frac_w;
		end
	end

	// S5: quadratic inner term; table lookup and slope
	logic [23:0]        cent_a;
	logic [19:0]        c1_sel;
	logic [15:0]        c2_sel;
	logic [39:0]        c2a;
	logic [ROM_AW-1:0]  rom_lo_addr;
	logic [ROM_AW-1:0]  rom_hi_addr;
	rom_word_t          rom_lo;
	rom_word_t          rom_hi;
	seg_t               seg_s5;
	logic [23:0]        a_s5;
	logic signed [40:0] p_s5;
	rom_word_t          lo_s5;
	logic signed [16:0] diff_s5;
	logic [29:0]        frac_s5;
	logic [29:0]        ex_s5;

	assign cent_a = q100_s4[60:37];

	always_comb begin
		unique case (seg_s4)
			SEG_EARLY: begin
				c1_sel = EARLY_C1;
				c2_sel = EARLY_C2;
			end
			SEG_MID: begin
				c1_sel = MID_C1;
				c2_sel = MID_C2;
			end
			default: begin
				c1_sel = '0;
				c2_sel = '0;
			end
		endcase
	end

	assign c2a         = 40'(c2_sel) * 40'(cent_a);
	assign rom_lo_addr = ROM_AW'(idx_s4);
	assign rom_hi_addr = rom_lo_addr + ROM_AW'(1);
	assign rom_lo      = DT_ROM[rom_lo_addr];
	assign rom_hi      = DT_ROM[rom_hi_addr];

	always_ff @(posedge clk) begin
		if (stage_en[5]) begin
			seg_s5  <= seg_s4;
			a_s5    <= cent_a;
			// p = c2*|t| - c1, so c*(c1 + c2*c) = |t| * p
			p_s5    <= $signed({1'b0, c2a}) - $signed({5'd0, c1_sel, 16'd0});
			lo_s5   <= rom_lo;
			diff_s5 <= 17'(rom_hi) - 17'(rom_lo);
			frac_s5 <= frac_s4;
			ex_s5   <= (frac_s4 > 30'd65536) ? (frac_s4 - 30'd65536) : 30'd0;
		end
	end

	// S6: |t| * p in two halves; slope times fraction; overrun squared
	logic signed [20:0] p_hi;
	seg_t               seg_s6;
	logic [43:0]        mlo_s6;
	logic signed [45:0] mhi_s6;
	rom_word_t          lo_s6;
	logic signed [47:0] t_s6;
	logic [59:0]        ex2_s6;

	assign p_hi = p_s5[40:20];

	always_ff @(posedge clk) begin
		if (stage_en[6]) begin
			seg_s6 <= seg_s5;
			mlo_s6 <= 44'(a_s5) * 44'(p_s5[19:0]);
			mhi_s6 <= 46'($signed({1'b0, a_s5}) * p_hi);
			lo_s6  <= lo_s5;
			t_s6   <= 48'(diff_s5 * $signed({1'b0, frac_s5}));
			ex2_s6 <= 60'(ex_s5) * 60'(ex_s5);
		end
	end

	// S7: quadratic in Q.32; interpolated value in Q.16 units of 10 ms
	logic [21:0]        c0_sel;
	logic signed [63:0] quad_sum;
	logic signed [48:0] lo_ext;
	seg_t               seg_s7;
	logic signed [63:0] quad_s7;
	logic signed [48:0] v_s7;
	logic [63:0]        e13_s7;

	always_comb begin
		unique case (seg_s6)
			SEG_EARLY: c0_sel = EARLY_C0;
			SEG_MID:   c0_sel = MID_C0;
			default:   c0_sel = '0;
		endcase
	end

	assign quad_sum = $signed({10'd0, c0_sel, 32'd0}) + (64'(mhi_s6) <<< 20)
		+ $signed({20'd0, mlo_s6});
	assign lo_ext = 49'(lo_s6);

	always_ff @(posedge clk) begin
		if (stage_en[7]) begin
			seg_s7  <= seg_s6;
			quad_s7 <= quad_sum;
			v_s7    <= (lo_ext <<< 16) + 49'(t_s6);
			// 13 * ex^2: 32.5 s per century squared in Q.32 ms
			e13_s7  <= (64'(ex2_s6) << 3) + (64'(ex2_s6) << 2) + 64'(ex2_s6);
		end
	end

	// S8: select segment result; table value times 655360 in Q.32 ms
	logic signed [63:0] v_ext;
	logic signed [63:0] q32_s8;

	assign v_ext = 64'(v_s7);

	always_ff @(posedge clk) begin
		if (stage_en[8]) begin
			if (seg_s7 == SEG_TABLE) begin
				q32_s8 <= (v_ext <<< 19) + (v_ext <<< 17) + $signed(e13_s7);
			end else begin
				q32_s8 <= quad_s7;
			end
		end
	end

	// S9: round to nearest ms, ties away from zero
	logic [63:0] q_mag;
	logic [63:0] q_rnd;
	logic [31:0] r_s9;
	logic        neg_s9;

	assign q_mag = q32_s8[63] ? 64'(-q32_s8) : 64'(q32_s8);
	assign q_rnd = q_mag + 64'h8000_0000;

	always_ff @(posedge clk) begin
		if (stage_en[9]) begin
			neg_s9 <= q32_s8[63];
			r_s9   <= q_rnd[63:32];
		end
	end

	// S10: saturate and apply sign into the output register
	logic [29:0] r_sat;
	dt_ms_t      ms_s10;

	assign r_sat = (r_s9 > MS_LIMIT) ? 30'(MS_LIMIT) : 30'(r_s9);

	always_ff @(posedge clk) begin
		if (stage_en[10]) begin
			ms_s10 <= neg_s9 ? -$signed({1'b0, r_sat}) : $signed({1'b0, r_sat});
		end
	end

	assign delta_t_ms = ms_s10;

	// Checks
	logic tab_vld_s4;
	logic out_in_range;

	assign tab_vld_s4   = vld_q[4] && (seg_s4 == SEG_TABLE);
	assign out_in_range = (delta_t_ms <= DT_MS_MAX) && (delta_t_ms >= -DT_MS_MAX);

	`ASSERT_ALWAYS(a_ready_only_when_full, clk, arst_n, jd_ready || (&vld_q))
	`ASSERT_IMPL(a_idx_clamped, clk, arst_n, tab_vld_s4, idx_s4 <= IDX_W'(IDX_MAX))
	`ASSERT_IMPL(a_out_saturated, clk, arst_n, dt_valid, out_in_range)

endmodule

`default_nettype wire
